// ----- src/hpqt_pkg.sv -----
// ----------------------------------------------------------------------------
// hpqt_pkg
// Shared types, constants and codes of the hierarchical page quota table.
// ----------------------------------------------------------------------------
package hpqt_pkg;

  localparam int ENTRY_COUNT  = 64;
  localparam int CHILDREN_MAX = 8;
  localparam int IDX_W        = $clog2(ENTRY_COUNT);

  localparam int ACT_W   = 3;
  localparam int PROC_W  = 6;
  localparam int PAGE_W  = 20;
  localparam int STAT_W  = 2;
  localparam int CHILD_W = 7;
  localparam int CNT_W   = 4;

  // wide enough for the child index of the last entry and for ENTRY_COUNT
  localparam int CIDX_W  = 12;

  localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};

  localparam logic [ACT_W-1:0] ACT_INIT     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CAN      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SPLIT    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CHARGE   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FREE_ONE = 3'd5;
  localparam logic [ACT_W-1:0] ACT_FREE_RUN = 3'd6;

  localparam logic [STAT_W-1:0] RES_OK    = 2'd0;
  localparam logic [STAT_W-1:0] RES_FAIL  = 2'd1;
  localparam logic [STAT_W-1:0] RES_FLOOR = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [PROC_W-1:0] proc_id;
    logic [PAGE_W-1:0] page_count;
    logic              alloc_granted;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CHILD_W-1:0] child_id;
    logic [PROC_W-1:0]  parent_id;
    logic [CNT_W-1:0]   child_count;
    logic [PAGE_W-1:0]  quota_out;
    logic [PAGE_W-1:0]  usage_out;
  } out_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0] quota;
    logic [PAGE_W-1:0] usage;
    logic [PROC_W-1:0] parent;
    logic [CNT_W-1:0]  children;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CHILD
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic child_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic split_ok;
  } dp_status_t;

endpackage

// ----- src/hierarchical_page_quota_table.sv -----
// On acceptance the entry is read into the RAM read register; the result then goes to the output register.
// One transaction at a time: entry read, then update and write back;
// a successful split then writes its child entry in a second RAM write.
// A stalled output holds the table in the update step until the result is taken.
// Reset (rst_n, synchronous) clears the written and used flags at once, so every entry
// reads as zero right away; no clearing pass, transactions are taken from the next cycle.
// ----------------------------------------------------------------------------
// hierarchical_page_quota_table
// Per-process page quota table with hierarchical quota splitting.
// ----------------------------------------------------------------------------
module hierarchical_page_quota_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  hpqt_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hpqt_pkg::out_item_t         out_data,
  input  logic                        cfg_wr_en,
  input  logic [hpqt_pkg::PAGE_W-1:0] cfg_wr_data
);

  hpqt_pkg::ctrl_cmd_t          cmd;
  hpqt_pkg::dp_status_t         dp_stat;
  logic                         ram_re, ram_we;
  logic [hpqt_pkg::IDX_W-1:0]   ram_raddr, ram_waddr;
  hpqt_pkg::entry_t             ram_rdata, ram_wdata;

  hpqt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .dp_stat  (dp_stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  hpqt_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .dp_stat     (dp_stat),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  hpqt_ram #(
    .WIDTH ($bits(hpqt_pkg::entry_t)),
    .DEPTH (hpqt_pkg::ENTRY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- src/hpqt_ram.sv -----
// ----------------------------------------------------------------------------
// hpqt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hpqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/hpqt_ctrl.sv -----
// ----------------------------------------------------------------------------
// hpqt_ctrl
// Sequencer: read entry, execute and write back, then child write on split.
// ----------------------------------------------------------------------------
module hpqt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  hpqt_pkg::dp_status_t   dp_stat,
  output hpqt_pkg::ctrl_cmd_t    cmd,
  output logic                   in_stall
);

  hpqt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hpqt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hpqt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = hpqt_pkg::S_EXEC;
      end
      hpqt_pkg::S_EXEC: begin
        // hold until the output register can take the result
        if (!dp_stat.out_busy) begin
          state_nxt = dp_stat.split_ok ? hpqt_pkg::S_CHILD : hpqt_pkg::S_IDLE;
        end
      end
      hpqt_pkg::S_CHILD: state_nxt = hpqt_pkg::S_IDLE;
      default:           state_nxt = hpqt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      hpqt_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      hpqt_pkg::S_EXEC: begin
        cmd.exec = !dp_stat.out_busy;
      end
      hpqt_pkg::S_CHILD: begin
        cmd.child_wr = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- src/hpqt_dpath.sv -----
// ----------------------------------------------------------------------------
// hpqt_dpath
// Request register, entry update logic, used and written flags, result register.
// ----------------------------------------------------------------------------
module hpqt_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hpqt_pkg::ctrl_cmd_t               cmd,
  output hpqt_pkg::dp_status_t              dp_stat,
  input  hpqt_pkg::in_item_t                in_data,
  input  logic                              cfg_wr_en,
  input  logic [hpqt_pkg::PAGE_W-1:0]       cfg_wr_data,
  output logic                              ram_re,
  output logic [hpqt_pkg::IDX_W-1:0]        ram_raddr,
  input  hpqt_pkg::entry_t                  ram_rdata,
  output logic                              ram_we,
  output logic [hpqt_pkg::IDX_W-1:0]        ram_waddr,
  output hpqt_pkg::entry_t                  ram_wdata,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hpqt_pkg::out_item_t               out_data
);

  localparam int IW = hpqt_pkg::IDX_W;
  localparam int CW = hpqt_pkg::CIDX_W;
  localparam int PW = hpqt_pkg::PAGE_W;

  logic [PW-1:0]                    root_quota_r;
  hpqt_pkg::in_item_t               req_r;
  logic                             rd_vld_r;
  logic [hpqt_pkg::ENTRY_COUNT-1:0] wr_vld_r;
  logic [hpqt_pkg::ENTRY_COUNT-1:0] used_r;
  logic                             out_valid_r;
  hpqt_pkg::out_item_t              out_r;

  hpqt_pkg::entry_t   cur, new_ent, show_ent, child_ent;
  logic [IW-1:0]      idx, cidx;
  logic               id_valid, is_root, used_show;
  logic [PW:0]        sum;
  logic [CW-1:0]      c_ext;
  logic               split_ok, wr_en;
  logic [IW-1:0]      wr_addr;
  logic [hpqt_pkg::STAT_W-1:0] res_status;

  // ---- request capture and RAM read ----
  assign ram_re    = cmd.accept;
  assign ram_raddr = IW'(in_data.proc_id);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r     <= 1'b0;
      root_quota_r <= '0;
    end else begin
      if (cmd.accept) rd_vld_r <= wr_vld_r[ram_raddr];
      if (cfg_wr_en)  root_quota_r <= cfg_wr_data;
    end
  end

  // ---- execute ----
  // entries never written read as zero
  assign cur      = rd_vld_r ? ram_rdata : '0;
  assign idx      = IW'(req_r.proc_id);
  assign id_valid = CW'(req_r.proc_id) < CW'(hpqt_pkg::ENTRY_COUNT);
  assign is_root  = (req_r.proc_id == '0);
  assign sum      = {1'b0, cur.usage} + {1'b0, req_r.page_count};
  assign c_ext    = CW'(req_r.proc_id) * CW'(hpqt_pkg::CHILDREN_MAX) + CW'(1)
                  + CW'(cur.children);
  assign cidx     = c_ext[IW-1:0];

  always_comb begin
    new_ent    = cur;
    show_ent   = cur;
    wr_en      = 1'b0;
    wr_addr    = idx;
    split_ok   = 1'b0;
    res_status = hpqt_pkg::RES_FAIL;
    if (req_r.action == hpqt_pkg::ACT_INIT) begin
      new_ent.quota    = root_quota_r;
      new_ent.usage    = '0;
      new_ent.parent   = '0;
      new_ent.children = '0;
      wr_en            = 1'b1;
      wr_addr          = '0;
      res_status       = hpqt_pkg::RES_OK;
      if (is_root) show_ent = new_ent;
    end else if (id_valid) begin
      case (req_r.action)
        hpqt_pkg::ACT_QUERY: begin
          res_status = hpqt_pkg::RES_OK;
        end
        hpqt_pkg::ACT_CAN: begin
          if (used_r[idx] && sum <= {1'b0, cur.quota}) res_status = hpqt_pkg::RES_OK;
        end
        hpqt_pkg::ACT_SPLIT: begin
          if (CW'(cur.children) < CW'(hpqt_pkg::CHILDREN_MAX)
              && c_ext < CW'(hpqt_pkg::ENTRY_COUNT)) begin
            split_ok         = 1'b1;
            new_ent.children = cur.children + 1'b1;
            new_ent.usage    = (sum > {1'b0, hpqt_pkg::PAGE_MAX}) ? hpqt_pkg::PAGE_MAX
                                                                   : sum[PW-1:0];
            wr_en            = 1'b1;
            res_status       = hpqt_pkg::RES_OK;
          end
        end
        hpqt_pkg::ACT_CHARGE: begin
          if (sum <= {1'b0, cur.quota} && req_r.alloc_granted && cur.usage < cur.quota) begin
            new_ent.usage = sum[PW-1:0];
            wr_en         = 1'b1;
            res_status    = hpqt_pkg::RES_OK;
          end
        end
        hpqt_pkg::ACT_FREE_ONE: begin
          if (cur.usage != '0) begin
            new_ent.usage = cur.usage - 1'b1;
            wr_en         = 1'b1;
            res_status    = hpqt_pkg::RES_OK;
          end else begin
            res_status = hpqt_pkg::RES_FLOOR;
          end
        end
        hpqt_pkg::ACT_FREE_RUN: begin
          wr_en = 1'b1;
          if (req_r.page_count > cur.usage) begin
            new_ent.usage = '0;
            res_status    = hpqt_pkg::RES_FLOOR;
          end else begin
            new_ent.usage = cur.usage - req_r.page_count;
            res_status    = hpqt_pkg::RES_OK;
          end
        end
        default: begin
          res_status = hpqt_pkg::RES_FAIL;
        end
      endcase
      if (wr_en) show_ent = new_ent;
    end
  end

  assign used_show = id_valid && (used_r[idx] ||
                     (req_r.action == hpqt_pkg::ACT_INIT && is_root));

  // ---- child entry for the second write of a split ----
  always_comb begin
    child_ent          = '0;
    child_ent.quota    = req_r.page_count;
    child_ent.parent   = req_r.proc_id;
  end

  assign ram_we    = (cmd.exec && wr_en) || cmd.child_wr;
  assign ram_waddr = cmd.child_wr ? cidx : wr_addr;
  assign ram_wdata = cmd.child_wr ? child_ent : new_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= '0;
      used_r   <= '0;
    end else begin
      if (cmd.exec && wr_en) begin
        wr_vld_r[wr_addr] <= 1'b1;
        if (req_r.action == hpqt_pkg::ACT_INIT) used_r[wr_addr] <= 1'b1;
      end
      if (cmd.child_wr) begin
        wr_vld_r[cidx] <= 1'b1;
        used_r[cidx]   <= 1'b1;
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r.status      <= res_status;
      out_r.child_id    <= split_ok ? c_ext[hpqt_pkg::CHILD_W-1:0]
                                    : hpqt_pkg::CHILD_W'(hpqt_pkg::ENTRY_COUNT);
      out_r.parent_id   <= used_show ? show_ent.parent   : '0;
      out_r.child_count <= used_show ? show_ent.children : '0;
      out_r.quota_out   <= used_show ? show_ent.quota    : '0;
      out_r.usage_out   <= id_valid  ? show_ent.usage    : '0;
    end
  end

  assign dp_stat.out_busy = out_valid_r && out_stall;
  assign dp_stat.split_ok = split_ok;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;

endmodule

// ----- src/hpqt_checker.sv -----
// ----------------------------------------------------------------------------
// hpqt_checker
// Port-level checks of the quota table, bound to the top level.
// ----------------------------------------------------------------------------
module hpqt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input hpqt_pkg::out_item_t out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction at a time: an accept is followed by a busy cycle
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction accepted while previous one in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

  // a child index is only reported by a successful split
  a_child_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.child_id != hpqt_pkg::CHILD_W'(hpqt_pkg::ENTRY_COUNT)
    |-> out_data.status == hpqt_pkg::RES_OK)
    else $error("child index with failing status");

  // a floored free leaves zero usage
  a_floor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == hpqt_pkg::RES_FLOOR |-> out_data.usage_out == '0)
    else $error("floored free with nonzero usage");

endmodule

bind hierarchical_page_quota_table hpqt_checker u_hpqt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/tb_hierarchical_page_quota_table.sv -----
// ----------------------------------------------------------------------------
// tb_hierarchical_page_quota_table
// Self-checking bench for the page quota table. A behavioral copy of the table
// predicts every result at input acceptance. Results are compared field by
// field in order. Traffic is a directed opener, then random quota-tree
// episodes under changing root quotas and idle/stall mixes, and finally a
// long output hold-off that backs the table up into its input.
// ----------------------------------------------------------------------------
module tb_hierarchical_page_quota_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [hpqt_pkg::ACT_W-1:0] ACT_UNUSED = 3'd7;

  localparam int RANDOM_PER_PHASE = 270;
  localparam int PRESSURE_ITEMS   = 40;
  localparam int LONG_HOLD        = 200;
  localparam int SETTLE_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT   = 4000;

  localparam int unsigned SEND_IDLE [4] = '{0, 49, 0, 35};
  localparam int unsigned RECV_STALL[4] = '{0, 0, 49, 35};

  // Behavioral copy of the table plus the queue of results still owed.
  class quota_ledger;
    logic [hpqt_pkg::PAGE_W-1:0] root_quota;
    logic [hpqt_pkg::PAGE_W-1:0] quota_mem [hpqt_pkg::ENTRY_COUNT];
    logic [hpqt_pkg::PAGE_W-1:0] usage_mem [hpqt_pkg::ENTRY_COUNT];
    logic [hpqt_pkg::PROC_W-1:0] parent_mem[hpqt_pkg::ENTRY_COUNT];
    logic [hpqt_pkg::CNT_W-1:0]  kids_mem  [hpqt_pkg::ENTRY_COUNT];
    bit                          in_use    [hpqt_pkg::ENTRY_COUNT];
    hpqt_pkg::out_item_t         pending_replies[$];
    int unsigned                 mismatches;

    function new();
      root_quota = '0;
      mismatches = 0;
      for (int i = 0; i < hpqt_pkg::ENTRY_COUNT; i++) begin
        quota_mem[i]  = '0;
        usage_mem[i]  = '0;
        parent_mem[i] = '0;
        kids_mem[i]   = '0;
        in_use[i]     = 1'b0;
      end
    endfunction

    // Apply one accepted transaction to the copy and queue its result.
    function void book_request(hpqt_pkg::in_item_t req);
      int unsigned id;
      int unsigned n;
      int unsigned nc;
      int unsigned child_idx;
      int unsigned total;
      int unsigned child;
      logic [hpqt_pkg::STAT_W-1:0] status;
      hpqt_pkg::out_item_t want;
      id     = req.proc_id;
      n      = req.page_count;
      child  = hpqt_pkg::ENTRY_COUNT;
      status = hpqt_pkg::RES_FAIL;
      case (req.action)
        hpqt_pkg::ACT_INIT: begin
          quota_mem[0]  = root_quota;
          usage_mem[0]  = '0;
          parent_mem[0] = '0;
          kids_mem[0]   = '0;
          in_use[0]     = 1'b1;
          status        = hpqt_pkg::RES_OK;
        end
        hpqt_pkg::ACT_QUERY: status = hpqt_pkg::RES_OK;
        hpqt_pkg::ACT_CAN: begin
          status = (in_use[id] && usage_mem[id] + n <= quota_mem[id]) ? hpqt_pkg::RES_OK
                                                                     : hpqt_pkg::RES_FAIL;
        end
        hpqt_pkg::ACT_SPLIT: begin
          nc        = kids_mem[id];
          child_idx = id * hpqt_pkg::CHILDREN_MAX + 1 + nc;
          if (nc < hpqt_pkg::CHILDREN_MAX && child_idx < hpqt_pkg::ENTRY_COUNT) begin
            total                 = usage_mem[id] + n;
            kids_mem[id]          = hpqt_pkg::CNT_W'(nc + 1);
            usage_mem[id]         = (total > hpqt_pkg::PAGE_MAX) ? hpqt_pkg::PAGE_MAX
                                                                 : hpqt_pkg::PAGE_W'(total);
            in_use[child_idx]     = 1'b1;
            quota_mem[child_idx]  = hpqt_pkg::PAGE_W'(n);
            usage_mem[child_idx]  = '0;
            parent_mem[child_idx] = hpqt_pkg::PROC_W'(id);
            kids_mem[child_idx]   = '0;
            child                 = child_idx;
            status                = hpqt_pkg::RES_OK;
          end
        end
        hpqt_pkg::ACT_CHARGE: begin
          total = usage_mem[id] + n;
          if (total <= quota_mem[id] && req.alloc_granted && usage_mem[id] < quota_mem[id]) begin
            usage_mem[id] = hpqt_pkg::PAGE_W'(total);
            status        = hpqt_pkg::RES_OK;
          end
        end
        hpqt_pkg::ACT_FREE_ONE: begin
          if (usage_mem[id] != 0) begin
            usage_mem[id] = usage_mem[id] - 1'b1;
            status        = hpqt_pkg::RES_OK;
          end else begin
            status = hpqt_pkg::RES_FLOOR;
          end
        end
        hpqt_pkg::ACT_FREE_RUN: begin
          if (n > usage_mem[id]) begin
            usage_mem[id] = '0;
            status        = hpqt_pkg::RES_FLOOR;
          end else begin
            usage_mem[id] = hpqt_pkg::PAGE_W'(usage_mem[id] - n);
            status        = hpqt_pkg::RES_OK;
          end
        end
        default: ;  // unused code: table untouched, refused
      endcase
      want.status   = status;
      want.child_id = hpqt_pkg::CHILD_W'(child);
      if (in_use[id]) begin
        want.parent_id   = parent_mem[id];
        want.child_count = kids_mem[id];
        want.quota_out   = quota_mem[id];
      end else begin
        want.parent_id   = '0;
        want.child_count = '0;
        want.quota_out   = '0;
      end
      want.usage_out = usage_mem[id];
      pending_replies.push_back(want);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void compare_reply(hpqt_pkg::out_item_t got);
      hpqt_pkg::out_item_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: result with no transaction pending, actual %p", $time, got);
        return;
      end
      want = pending_replies.pop_front();
      check_field("status",      want.status,      got.status);
      check_field("child_id",    want.child_id,    got.child_id);
      check_field("parent_id",   want.parent_id,   got.parent_id);
      check_field("child_count", want.child_count, got.child_count);
      check_field("quota_out",   want.quota_out,   got.quota_out);
      check_field("usage_out",   want.usage_out,   got.usage_out);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  hpqt_pkg::in_item_t          in_data;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  hpqt_pkg::out_item_t         out_data;
  logic                        cfg_wr_en;
  logic [hpqt_pkg::PAGE_W-1:0] cfg_wr_data;

  quota_ledger ledger = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  hierarchical_page_quota_table dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: both channels sampled on the edge, pre-update values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ledger.book_request(in_data);
      if (out_valid && !out_stall) ledger.compare_reply(out_data);
    end
  end

  // Receiver: random stalls, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  task automatic offer_request(input hpqt_pkg::in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic offer_fields(input logic [hpqt_pkg::ACT_W-1:0] act, input int unsigned id,
                              input int unsigned n, input bit grant);
    hpqt_pkg::in_item_t req;
    req.action        = act;
    req.proc_id       = hpqt_pkg::PROC_W'(id);
    req.page_count    = hpqt_pkg::PAGE_W'(n);
    req.alloc_granted = grant;
    offer_request(req);
  endtask

  task automatic wait_all_replies();
    in_valid <= 1'b0;
    while (ledger.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_root_quota(input logic [hpqt_pkg::PAGE_W-1:0] value);
    wait_all_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ledger.root_quota = value;
  endtask

  // Random transaction biased toward the top of the tree and toward
  // counts right at the quota or usage boundary.
  function automatic hpqt_pkg::in_item_t pick_request();
    hpqt_pkg::in_item_t r;
    int unsigned        roll;
    int unsigned        room;
    int unsigned        used;
    roll = $urandom_range(99);
    if (roll < 2)       r.action = hpqt_pkg::ACT_INIT;
    else if (roll < 12) r.action = hpqt_pkg::ACT_QUERY;
    else if (roll < 26) r.action = hpqt_pkg::ACT_CAN;
    else if (roll < 42) r.action = hpqt_pkg::ACT_SPLIT;
    else if (roll < 68) r.action = hpqt_pkg::ACT_CHARGE;
    else if (roll < 79) r.action = hpqt_pkg::ACT_FREE_ONE;
    else if (roll < 97) r.action = hpqt_pkg::ACT_FREE_RUN;
    else                r.action = ACT_UNUSED;
    roll = $urandom_range(99);
    if (roll < 30)      r.proc_id = hpqt_pkg::PROC_W'($urandom_range(8));
    else if (roll < 55) r.proc_id = hpqt_pkg::PROC_W'($urandom_range(16));
    else                r.proc_id = hpqt_pkg::PROC_W'($urandom());
    r.alloc_granted = ($urandom_range(9) != 0);
    used = ledger.usage_mem[r.proc_id];
    room = (ledger.quota_mem[r.proc_id] > used) ? ledger.quota_mem[r.proc_id] - used : 0;
    roll = $urandom_range(99);
    if (roll < 30)      r.page_count = hpqt_pkg::PAGE_W'($urandom_range(15));
    else if (roll < 50) r.page_count = hpqt_pkg::PAGE_W'($urandom_range(4095));
    else if (roll < 65) r.page_count = hpqt_pkg::PAGE_W'($urandom());
    else if (roll < 70) r.page_count = hpqt_pkg::PAGE_MAX;
    else if (roll < 75) r.page_count = '0;
    else if (r.action == hpqt_pkg::ACT_SPLIT)
      r.page_count = hpqt_pkg::PAGE_W'(room >> $urandom_range(3, 1));
    else if (r.action == hpqt_pkg::ACT_FREE_RUN)
      r.page_count = hpqt_pkg::PAGE_W'(used + $urandom_range(2) - 1);
    else
      r.page_count = hpqt_pkg::PAGE_W'(room + $urandom_range(2) - 1);
    return r;
  endfunction

  initial begin
    logic [hpqt_pkg::PAGE_W-1:0] quota_pick;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    load_root_quota(hpqt_pkg::PAGE_MAX);
    offer_fields(hpqt_pkg::ACT_QUERY,    0,  0,                  1'b1);  // entry never used
    offer_fields(hpqt_pkg::ACT_CAN,      63, 0,                  1'b1);  // unused entry refused
    offer_fields(hpqt_pkg::ACT_FREE_ONE, 5,  0,                  1'b1);  // already zero: floored
    offer_fields(hpqt_pkg::ACT_FREE_RUN, 5,  5,                  1'b1);  // run longer than usage
    offer_fields(ACT_UNUSED,             0,  7,                  1'b1);
    offer_fields(hpqt_pkg::ACT_INIT,     0,  0,                  1'b0);
    offer_fields(hpqt_pkg::ACT_CAN,      0,  hpqt_pkg::PAGE_MAX, 1'b0);
    offer_fields(hpqt_pkg::ACT_CHARGE,   0,  100,                1'b0);  // no grant
    offer_fields(hpqt_pkg::ACT_CHARGE,   0,  100,                1'b1);
    offer_fields(hpqt_pkg::ACT_CHARGE,   0,  hpqt_pkg::PAGE_MAX, 1'b1);  // over quota
    offer_fields(hpqt_pkg::ACT_FREE_ONE, 0,  0,                  1'b1);
    offer_fields(hpqt_pkg::ACT_FREE_RUN, 0,  9,                  1'b1);
    offer_fields(hpqt_pkg::ACT_SPLIT,    0,  hpqt_pkg::PAGE_MAX, 1'b1);  // parent usage saturates
    offer_fields(hpqt_pkg::ACT_CHARGE,   0,  0,                  1'b1);  // usage sits at quota
    offer_fields(hpqt_pkg::ACT_SPLIT,    8,  1,                  1'b1);  // child index past table
    offer_fields(hpqt_pkg::ACT_SPLIT,    7,  3,                  1'b1);  // parent not in use, split still taken
    offer_fields(hpqt_pkg::ACT_FREE_RUN, 0,  hpqt_pkg::PAGE_MAX, 1'b1);
    offer_fields(hpqt_pkg::ACT_CHARGE,   1,  hpqt_pkg::PAGE_MAX, 1'b1);
    for (int k = 0; k < 8; k++)                      // last one: parent is full
      offer_fields(hpqt_pkg::ACT_SPLIT, 0, $urandom_range(1000), 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       quota_pick = '0;
        1:       quota_pick = hpqt_pkg::PAGE_MAX;
        2:       quota_pick = hpqt_pkg::PAGE_W'($urandom_range(5000, 1));
        default: quota_pick = hpqt_pkg::PAGE_W'($urandom());
      endcase
      load_root_quota(quota_pick);
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      offer_fields(hpqt_pkg::ACT_INIT, $urandom_range(63), $urandom(), $urandom_range(1));
      for (int k = 1; k < RANDOM_PER_PHASE; k++) offer_request(pick_request());
    end

    // Back-pressure: output held while the sender keeps offering.
    load_root_quota(hpqt_pkg::PAGE_W'(4096));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    offer_fields(hpqt_pkg::ACT_INIT, 0, 0, 1'b1);
    for (int k = 1; k < PRESSURE_ITEMS; k++) offer_request(pick_request());

    wait_all_replies();
    if (ledger.mismatches == 0 && ledger.pending_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
